/* sv/rtks_pkg.sv */
// Package with the shared types and constants of the record table key search block.
package rtks_pkg;

    localparam int YEAR_W   = 12;
    localparam int VOLUME_W = 17;
    localparam int SPEED_W  = 10;
    localparam int KEY_W    = 17;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        FLD_YEAR   = 2'd0,
        FLD_VOLUME = 2'd1,
        FLD_SPEED  = 2'd2,
        FLD_NONE   = 2'd3
    } t_fld;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [VOLUME_W-1:0] volume;
        logic [SPEED_W-1:0]  speed;
    } t_rec;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

    typedef struct packed {
        logic                found;
        logic                used_binary;
        logic                table_full;
        logic [YEAR_W-1:0]   out_year;
        logic [VOLUME_W-1:0] out_volume;
        logic [SPEED_W-1:0]  out_speed;
    } t_res;

endpackage

/* sv/rtks_if.sv */
// Channel interfaces for items, results and the configuration register write.
interface rtks_item_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [1:0]                    key_field;
    logic [rtks_pkg::KEY_W-1:0]    search_key;
    logic [rtks_pkg::YEAR_W-1:0]   rec_year;
    logic [rtks_pkg::VOLUME_W-1:0] rec_volume;
    logic [rtks_pkg::SPEED_W-1:0]  rec_speed;

    modport source (
        output valid, operation, key_field, search_key, rec_year, rec_volume, rec_speed,
        input  ready
    );
    modport sink (
        input  valid, operation, key_field, search_key, rec_year, rec_volume, rec_speed,
        output ready
    );
endinterface

interface rtks_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic                          used_binary;
    logic                          table_full;
    logic [rtks_pkg::YEAR_W-1:0]   out_year;
    logic [rtks_pkg::VOLUME_W-1:0] out_volume;
    logic [rtks_pkg::SPEED_W-1:0]  out_speed;

    modport source (
        output valid, found, used_binary, table_full, out_year, out_volume, out_speed,
        input  ready
    );
    modport sink (
        input  valid, found, used_binary, table_full, out_year, out_volume, out_speed,
        output ready
    );
endinterface

interface rtks_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/record_table_key_search.sv */
// Top level of the record table key search block: sequencer, record RAM and compare unit.
//
// The block keeps up to TABLE_DEPTH records (year, engine volume in units of 0.0001 litre,
// top speed) in a single RAM with one write port and one registered read port. Each input
// transfer carries one operation and produces exactly one result transfer. Append, clear and
// unknown operations go from idle to the done state, as does a search on an empty table;
// from there the result is loaded into the output register once that register is free. When
// the sorted_field register names the searched field, a binary search runs: every probe is
// one RAM read followed by one compare, and any matching record may be returned. Otherwise
// a linear scan streams one record per cycle out of the RAM through the compare unit and
// returns the first match in append order; between items the sequencer passes through the
// done state and returns to idle. The single RAM read port and the one shared compare unit
// set the search speed. The input channel is ready only while the sequencer is idle; a
// finished result waits in the output register, and the next input transfer is taken while
// it waits. The configuration channel is always ready and must only be written while the
// block is idle. Engine volume is fixed point, so a volume key matches on exact equality;
// year and speed keys are compared zero extended.
module record_table_key_search #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtks_item_if.sink   i_item,
    rtks_res_if.source  o_result,
    rtks_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = $bits(rtks_pkg::t_rec);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LIN  = 5'b00010,
        S_BRD  = 5'b00100,
        S_BCMP = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // Control state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_sorted;
    logic            r_pend, n_pend;
    logic            r_ovalid, n_ovalid;

    // Search working registers and result payload.
    rtks_pkg::t_fld             r_fld, n_fld;
    logic [rtks_pkg::KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_lo, n_lo;
    logic [CW-1:0]              r_hx, n_hx;
    logic [CW-1:0]              r_mid, n_mid;
    rtks_pkg::t_res             r_res, n_res;
    rtks_pkg::t_res             r_out, n_out;

    logic            item_xfer;
    logic            out_free;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [RW-1:0]   ram_rdata;
    rtks_pkg::t_rec  wr_rec;
    rtks_pkg::t_rec  rd_rec;
    rtks_pkg::t_cmp  cmp;
    logic [CW-1:0]   mid;
    logic            lin_issue;
    logic            has_room;

    assign item_xfer = i_item.valid && i_item.ready;
    assign out_free  = !r_ovalid || o_result.ready;
    assign has_room  = r_count < CW'(TABLE_DEPTH);

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    // The record is written at the current fill position on an accepted append.
    assign wr_rec.year   = i_item.rec_year;
    assign wr_rec.volume = i_item.rec_volume;
    assign wr_rec.speed  = i_item.rec_speed;
    assign ram_we = item_xfer && (rtks_pkg::t_op'(i_item.operation) == rtks_pkg::OP_APPEND)
                    && has_room;

    // The binary search works on a half-open window [lo, hx); the probe is its lower middle,
    // which matches lo + (hi - lo) / 2 with hi = hx - 1.
    assign mid       = r_lo + ((r_hx - r_lo - CW'(1)) >> 1);
    assign lin_issue = r_idx < r_count;
    assign ram_raddr = (r_state == S_BRD) ? mid[AW-1:0] : r_idx[AW-1:0];

    rtks_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_rec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_rec = rtks_pkg::t_rec'(ram_rdata);

    rtks_cmp u_cmp (
        .i_rec (rd_rec),
        .i_fld (r_fld),
        .i_key (r_key),
        .o_cmp (cmp)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pend   = r_pend;
        n_ovalid = r_ovalid;
        n_fld    = r_fld;
        n_key    = r_key;
        n_idx    = r_idx;
        n_lo     = r_lo;
        n_hx     = r_hx;
        n_mid    = r_mid;
        n_res    = r_res;
        n_out    = r_out;

        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (item_xfer) begin
                    n_res   = '0;
                    n_fld   = rtks_pkg::t_fld'(i_item.key_field);
                    n_key   = i_item.search_key;
                    n_state = S_DONE;
                    case (rtks_pkg::t_op'(i_item.operation))
                        rtks_pkg::OP_APPEND: begin
                            if (has_room) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_res.table_full = 1'b1;
                            end
                        end
                        rtks_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        rtks_pkg::OP_SEARCH: begin
                            if (r_count != '0) begin
                                if (r_sorted == i_item.key_field) begin
                                    n_res.used_binary = 1'b1;
                                    n_lo    = '0;
                                    n_hx    = r_count;
                                    n_state = S_BRD;
                                end else begin
                                    n_idx   = '0;
                                    n_pend  = 1'b0;
                                    n_state = S_LIN;
                                end
                            end
                        end
                        default: begin
                            // Unknown operation: nothing changes, the result is all zero.
                        end
                    endcase
                end
            end
            S_LIN: begin
                // One read issued and one record compared per cycle; the record read in
                // the previous cycle is the one that the compare unit sees now.
                if (r_pend && cmp.eq) begin
                    n_res.found      = 1'b1;
                    n_res.out_year   = rd_rec.year;
                    n_res.out_volume = rd_rec.volume;
                    n_res.out_speed  = rd_rec.speed;
                    n_pend           = 1'b0;
                    n_state          = S_DONE;
                end else if (!r_pend && !lin_issue) begin
                    n_state = S_DONE;
                end else begin
                    n_pend = lin_issue;
                    if (lin_issue) begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            S_BRD: begin
                if (r_lo < r_hx) begin
                    n_mid   = mid;
                    n_state = S_BCMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BCMP: begin
                if (cmp.eq) begin
                    n_res.found      = 1'b1;
                    n_res.out_year   = rd_rec.year;
                    n_res.out_volume = rd_rec.volume;
                    n_res.out_speed  = rd_rec.speed;
                    n_state          = S_DONE;
                end else begin
                    if (cmp.lt) begin
                        n_lo = r_mid + CW'(1);
                    end else begin
                        n_hx = r_mid;
                    end
                    n_state = S_BRD;
                end
            end
            S_DONE: begin
                // The result moves to the output register as soon as that register is free.
                if (out_free) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sorted <= rtks_pkg::FLD_NONE;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_sorted <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fld <= n_fld;
        r_key <= n_key;
        r_idx <= n_idx;
        r_lo  <= n_lo;
        r_hx  <= n_hx;
        r_mid <= n_mid;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.found       = r_out.found;
    assign o_result.used_binary = r_out.used_binary;
    assign o_result.table_full  = r_out.table_full;
    assign o_result.out_year    = r_out.out_year;
    assign o_result.out_volume  = r_out.out_volume;
    assign o_result.out_speed   = r_out.out_speed;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("record count beyond table depth");

    // Every compare cycle of the binary search follows its read cycle.
    a_bcmp_after_brd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BCMP) |-> ($past(r_state) == S_BRD))
        else $error("binary compare without a preceding read");

    // The binary search window stays inside the filled part of the table.
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BRD || r_state == S_BCMP) |-> (r_hx <= r_count && r_lo <= r_count))
        else $error("binary search window outside the table");

    // A refused append never reports a search hit.
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.table_full) |-> (!r_out.found && !r_out.used_binary))
        else $error("refused append carries search flags");

    // An accepted item always leaves the idle state.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_xfer |=> (r_state != S_IDLE))
        else $error("item transfer did not start the sequencer");

endmodule

/* sv/rtks_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module rtks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rtks_cmp.sv */
// Shared key compare unit: selects a record field and compares it with the key.
module rtks_cmp (
    input  rtks_pkg::t_rec                i_rec,
    input  rtks_pkg::t_fld                i_fld,
    input  logic [rtks_pkg::KEY_W-1:0]    i_key,
    output rtks_pkg::t_cmp                o_cmp
);

    logic [rtks_pkg::KEY_W-1:0] fld_val;
    logic                       fld_ok;

    always_comb begin
        fld_val = '0;
        fld_ok  = 1'b1;
        case (i_fld)
            rtks_pkg::FLD_YEAR:   fld_val = rtks_pkg::KEY_W'(i_rec.year);
            rtks_pkg::FLD_VOLUME: fld_val = i_rec.volume;
            rtks_pkg::FLD_SPEED:  fld_val = rtks_pkg::KEY_W'(i_rec.speed);
            default:              fld_ok  = 1'b0;
        endcase
    end

    // An invalid field never matches and never steers the search upward.
    assign o_cmp.eq = fld_ok && (fld_val == i_key);
    assign o_cmp.lt = fld_ok && (fld_val < i_key);

endmodule
